@@ sv/go_back_n_sender_core_assert.svh @@
// ----------------------------------------------------------------------------
// Go-Back-N sender assertion macros
// Shorthand for the clocked, reset-qualified checks used by the core.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_CORE_ASSERT_SVH
`define GO_BACK_N_SENDER_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define GBNS_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("go_back_n_sender_core: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define GBNS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("go_back_n_sender_core: next-cycle check failed");

`endif

@@ sv/gbns_pkg.sv @@
// ----------------------------------------------------------------------------
// gbns_pkg
// Types, codes and defaults shared by the Go-Back-N sender modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbns_pkg;

  localparam int unsigned MaxWindowDefault  = 16;
  localparam int unsigned PayloadMaxDefault = 1024;

  localparam logic [4:0]  WindowSizeReset   = 5'd16;
  localparam logic [23:0] TimeoutTicksReset = 24'd1000;

  typedef enum logic [1:0] {
    ACT_OFFER = 2'd0,
    ACT_ACK   = 2'd1,
    ACT_TICK  = 2'd2
  } gbns_action_e;

  typedef enum logic [1:0] {
    KIND_FIRST   = 2'd0,
    KIND_RETX    = 2'd1,
    KIND_REFUSED = 2'd2
  } gbns_kind_e;

  typedef enum logic {
    CFG_WINDOW_SIZE   = 1'b0,
    CFG_TIMEOUT_TICKS = 1'b1
  } gbns_cfg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RETX = 1'b1
  } gbns_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic send_first;
    logic send_refused;
    logic ack_advance;
    logic timer_restart;
    logic timer_stop;
    logic timer_dec;
    logic retx_start;
    logic retx_emit;
  } gbns_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic room;
    logic none_outstanding;
    logic ack_hit;
    logic ack_drains;
    logic timer_running;
    logic timer_expire;
    logic retx_last;
  } gbns_status_t;

endpackage

`default_nettype wire

@@ sv/gbns_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbns_ctrl
// Controller: decodes each accepted beat and sequences retransmit bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbns_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            action_i,
  input  wire gbns_pkg::gbns_status_t status_i,
  output gbns_pkg::gbns_cmd_t        cmd_o
);

  gbns_pkg::gbns_state_e state_q, state_d;
  logic                  accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbns_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    unique case (state_q)
      gbns_pkg::ST_IDLE: begin
        in_stall_o = !status_i.out_free;
        accept     = in_valid_i && status_i.out_free;
        if (accept) begin
          unique case (gbns_pkg::gbns_action_e'(action_i))
            gbns_pkg::ACT_OFFER: begin
              if (status_i.room) begin
                cmd_o.send_first    = 1'b1;
                cmd_o.timer_restart = status_i.none_outstanding;
              end else begin
                cmd_o.send_refused = 1'b1;
              end
            end
            gbns_pkg::ACT_ACK: begin
              if (status_i.ack_hit) begin
                cmd_o.ack_advance   = 1'b1;
                cmd_o.timer_stop    = status_i.ack_drains;
                cmd_o.timer_restart = !status_i.ack_drains;
              end else begin
                cmd_o.timer_restart = 1'b1;
              end
            end
            gbns_pkg::ACT_TICK: begin
              if (status_i.timer_running) begin
                if (!status_i.timer_expire) begin
                  cmd_o.timer_dec = 1'b1;
                end else begin
                  cmd_o.timer_restart = 1'b1;
                  if (!status_i.none_outstanding) begin
                    cmd_o.retx_start = 1'b1;
                    state_d          = gbns_pkg::ST_RETX;
                  end
                end
              end
            end
            default: begin
              // Unused action code: the beat is dropped.
            end
          endcase
        end
      end
      gbns_pkg::ST_RETX: begin
        if (status_i.out_free) begin
          cmd_o.retx_emit = 1'b1;
          if (status_i.retx_last) begin
            state_d = gbns_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = gbns_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/gbns_dp.sv @@
// ----------------------------------------------------------------------------
// gbns_dp
// Datapath: window pointers, slot length memory, timer, config and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbns_dp #(
  parameter int unsigned MAX_WINDOW  = gbns_pkg::MaxWindowDefault,
  parameter int unsigned PAYLOAD_MAX = gbns_pkg::PayloadMaxDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [23:0]            cfg_wdata_i,
  input  wire logic [10:0]            chunk_length_i,
  input  wire logic                   ack_is_data_ack_i,
  input  wire logic [15:0]            ack_seq_i,
  input  wire logic                   out_stall_i,
  output logic                        out_valid_o,
  output logic [1:0]                  kind_o,
  output logic [15:0]                 seq_num_o,
  output logic [10:0]                 chunk_length_res_o,
  output logic                        last_o,
  input  wire gbns_pkg::gbns_cmd_t    cmd_i,
  output gbns_pkg::gbns_status_t      status_o
);

  localparam int unsigned SW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUMW = SW + 2;
  localparam logic [15:0]   MaxWin16   = 16'(MAX_WINDOW);
  localparam logic [SUMW-1:0] MaxWinSum = SUMW'(MAX_WINDOW);
  localparam logic [SW-1:0] LastSlot   = SW'(MAX_WINDOW - 1);
  localparam logic [16:0]   PayMax17   = 17'(PAYLOAD_MAX);

  // Configuration.
  logic [4:0]  win_size_q;
  logic [23:0] timeout_q;

  // Window and timer state.
  logic [15:0]   base_q, base_d;
  logic [15:0]   next_q, next_d;
  logic [SW-1:0] head_q, head_d;
  logic          run_q, run_d;
  logic [23:0]   count_q, count_d;

  // Retransmit burst.
  logic [SW-1:0] rslot_q, rslot_d;
  logic [CW-1:0] rcnt_q, rcnt_d;
  logic [CW-1:0] ridx_q, ridx_d;

  // Slot memory.
  logic [10:0]   slot_mem [MAX_WINDOW];
  logic [10:0]   rd_data_q;
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] wr_addr;

  // Output register.
  logic                 out_valid_q;
  gbns_pkg::gbns_kind_e out_kind_q;
  logic [15:0]          out_seq_q;
  logic [10:0]          out_len_q;
  logic                 out_last_q;

  logic [15:0]   outstanding;
  logic [15:0]   win_eff;
  logic [15:0]   ack_off;
  logic [15:0]   ack_next;
  logic [23:0]   timeout_eff;
  logic [10:0]   len_sat;
  logic [SUMW-1:0] wr_sum;
  logic [SUMW-1:0] head_sum;
  logic [SW-1:0] rslot_inc;
  logic          out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= gbns_pkg::WindowSizeReset;
      timeout_q  <= gbns_pkg::TimeoutTicksReset;
    end else if (cfg_we_i) begin
      unique case (gbns_pkg::gbns_cfg_e'(cfg_idx_i))
        gbns_pkg::CFG_WINDOW_SIZE:   win_size_q <= cfg_wdata_i[4:0];
        gbns_pkg::CFG_TIMEOUT_TICKS: timeout_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    outstanding = next_q - base_q;
    if (win_size_q == 5'd0) begin
      win_eff = 16'd1;
    end else if (16'(win_size_q) > MaxWin16) begin
      win_eff = MaxWin16;
    end else begin
      win_eff = 16'(win_size_q);
    end
    timeout_eff = (timeout_q == 24'd0) ? 24'd1 : timeout_q;
    len_sat     = ({6'd0, chunk_length_i} > PayMax17) ? PayMax17[10:0] : chunk_length_i;
    ack_off     = ack_seq_i - base_q;
    ack_next    = ack_seq_i + 16'd1;

    // Ring positions stay below twice the depth, so one subtract wraps them.
    wr_sum   = SUMW'(head_q) + SUMW'(outstanding[SW-1:0]);
    if (wr_sum >= MaxWinSum) wr_sum = wr_sum - MaxWinSum;
    wr_addr  = wr_sum[SW-1:0];
    head_sum = SUMW'(head_q) + SUMW'(ack_off[SW-1:0]) + SUMW'(1);
    if (head_sum >= MaxWinSum) head_sum = head_sum - MaxWinSum;
    rslot_inc = (rslot_q == LastSlot) ? '0 : rslot_q + SW'(1);

    out_free = !out_valid_q || !out_stall_i;

    status_o.out_free         = out_free;
    status_o.room             = (outstanding < win_eff) && (outstanding < MaxWin16);
    status_o.none_outstanding = (outstanding == 16'd0);
    status_o.ack_hit          = ack_is_data_ack_i && (ack_off < outstanding);
    status_o.ack_drains       = (ack_next == next_q);
    status_o.timer_running    = run_q;
    status_o.timer_expire     = (count_q[23:1] == 23'd0);
    status_o.retx_last        = (ridx_q + CW'(1) == rcnt_q);
  end

  always_comb begin
    base_d  = base_q;
    next_d  = next_q;
    head_d  = head_q;
    run_d   = run_q;
    count_d = count_q;
    rslot_d = rslot_q;
    rcnt_d  = rcnt_q;
    ridx_d  = ridx_q;
    rd_en   = 1'b0;
    rd_addr = rslot_inc;

    if (cmd_i.send_first) begin
      next_d = next_q + 16'd1;
    end
    if (cmd_i.ack_advance) begin
      base_d = ack_next;
      head_d = head_sum[SW-1:0];
    end
    if (cmd_i.timer_restart) begin
      run_d   = 1'b1;
      count_d = timeout_eff;
    end else if (cmd_i.timer_stop) begin
      run_d   = 1'b0;
      count_d = '0;
    end else if (cmd_i.timer_dec) begin
      count_d = count_q - 24'd1;
    end
    if (cmd_i.retx_start) begin
      rslot_d = head_q;
      rcnt_d  = outstanding[CW-1:0];
      ridx_d  = '0;
      rd_en   = 1'b1;
      rd_addr = head_q;
    end else if (cmd_i.retx_emit) begin
      rslot_d = rslot_inc;
      ridx_d  = ridx_q + CW'(1);
      rd_en   = !status_o.retx_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      next_q  <= '0;
      head_q  <= '0;
      run_q   <= 1'b0;
      count_q <= '0;
      rslot_q <= '0;
      rcnt_q  <= '0;
      ridx_q  <= '0;
    end else begin
      base_q  <= base_d;
      next_q  <= next_d;
      head_q  <= head_d;
      run_q   <= run_d;
      count_q <= count_d;
      rslot_q <= rslot_d;
      rcnt_q  <= rcnt_d;
      ridx_q  <= ridx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.send_first) begin
      slot_mem[wr_addr] <= len_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.send_first || cmd_i.send_refused || cmd_i.retx_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.send_first) begin
      out_kind_q <= gbns_pkg::KIND_FIRST;
      out_seq_q  <= next_q;
      out_len_q  <= len_sat;
      out_last_q <= 1'b1;
    end else if (cmd_i.send_refused) begin
      out_kind_q <= gbns_pkg::KIND_REFUSED;
      out_seq_q  <= next_q;
      out_len_q  <= '0;
      out_last_q <= 1'b1;
    end else if (cmd_i.retx_emit) begin
      out_kind_q <= gbns_pkg::KIND_RETX;
      out_seq_q  <= base_q + 16'(ridx_q);
      out_len_q  <= rd_data_q;
      out_last_q <= status_o.retx_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = out_kind_q;
  assign seq_num_o          = out_seq_q;
  assign chunk_length_res_o = out_len_q;
  assign last_o             = out_last_q;

endmodule

`default_nettype wire

@@ sv/go_back_n_sender_core.sv @@
// ----------------------------------------------------------------------------
// go_back_n_sender_core
// Go-Back-N sender window with retransmit timer and slot length memory.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Payload
//   cfg      in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//   in       in         in_valid_i/in_stall_o   action, chunk_length, ack flag, ack_seq
//   out      out        out_valid_o/out_stall_i kind, seq_num, chunk_length_res, last
//
// An offer's result sits in the output register the cycle after acceptance.
// A timer expiry with n packets outstanding holds off input while the slot
// memory read port streams one length per cycle into the output, as long as
// the output is not stalled.
// Reset clears pointers and timer at once; the slot memory needs no clearing.
// A stall on the output holds both the burst and new input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "go_back_n_sender_core_assert.svh"

module go_back_n_sender_core #(
  parameter int unsigned MAX_WINDOW  = gbns_pkg::MaxWindowDefault,
  parameter int unsigned PAYLOAD_MAX = gbns_pkg::PayloadMaxDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [10:0] chunk_length_i,
  input  wire logic        ack_is_data_ack_i,
  input  wire logic [15:0] ack_seq_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [15:0]      seq_num_o,
  output logic [10:0]      chunk_length_res_o,
  output logic             last_o
);

  gbns_pkg::gbns_cmd_t    cmd;
  gbns_pkg::gbns_status_t status;

  gbns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gbns_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .chunk_length_i     (chunk_length_i),
    .ack_is_data_ack_i  (ack_is_data_ack_i),
    .ack_seq_i          (ack_seq_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .kind_o             (kind_o),
    .seq_num_o          (seq_num_o),
    .chunk_length_res_o (chunk_length_res_o),
    .last_o             (last_o),
    .cmd_i              (cmd),
    .status_o           (status)
  );

  // An input beat is only taken when the output register can take its result.
  `GBNS_ASSERT_NOW(a_in_needs_out_room, clk_i, rst_ni,
    in_valid_i && !in_stall_o, !out_valid_o || !out_stall_i)

  // Every accepted offer shows up as a single, final first-send or refusal.
  `GBNS_ASSERT_NEXT(a_offer_result, clk_i, rst_ni,
    in_valid_i && !in_stall_o && (action_i == gbns_pkg::ACT_OFFER),
    out_valid_o && last_o && (kind_o != gbns_pkg::KIND_RETX))

  // A burst that has not reached its last packet keeps the output filled.
  `GBNS_ASSERT_NEXT(a_burst_continues, clk_i, rst_ni,
    cmd.retx_emit && !status.retx_last,
    out_valid_o && !last_o && (kind_o == gbns_pkg::KIND_RETX) && in_stall_o)

endmodule

`default_nettype wire
